>>> design/assert_macros.svh
// Assertion macros used by the priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MPQ_AST_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MPQ_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/mpq_pkg.sv
// Types, constants and the pair ordering for the min priority queue.
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int TOTAL_W  = 7;

    // Action codes
    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] major;
        logic signed [KEY_W-1:0] minor;
    } pair_t;

    // Contents of one cell as seen by its neighbors
    typedef struct packed {
        logic  valid;
        pair_t pair;
    } cell_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic  ins;
        logic  ext;
        pair_t pair;
    } cell_ctrl_t;

    // Major key first, then minor key, both signed
    function automatic logic pair_less(input pair_t a, input pair_t b);
        logic res;
        if (a.major != b.major)
            res = (a.major < b.major);
        else
            res = (a.minor < b.minor);
        return res;
    endfunction

endpackage

>>> design/mpq_cell.sv
// One cell of the sorted queue: holds one pair, shifts toward either neighbor.
`timescale 1ns / 1ps

module mpq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mpq_pkg::cell_ctrl_t ctrl,
    input  mpq_pkg::cell_t     left,
    input  logic               left_less,
    input  mpq_pkg::cell_t     right,
    output mpq_pkg::cell_t     cur,
    output logic               less
);
    import mpq_pkg::*;

    logic  valid_reg, valid_next;
    pair_t pair_reg, pair_next;

    // New pair belongs in front of this entry (empty cells act as infinity)
    assign less = !valid_reg || pair_less(ctrl.pair, pair_reg);

    // Insert: keep, take new pair, or take left neighbor's; extract: take right
    always_comb
    begin
        valid_next = valid_reg;
        pair_next  = pair_reg;
        if (ctrl.ins && less)
        begin
            if (left_less)
            begin
                valid_next = left.valid;
                pair_next  = left.pair;
            end
            else
            begin
                valid_next = 1'b1;
                pair_next  = ctrl.pair;
            end
        end
        else if (ctrl.ext)
        begin
            valid_next = right.valid;
            pair_next  = right.pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    assign cur.valid = valid_reg;
    assign cur.pair  = pair_reg;

endmodule

>>> design/min_priority_queue_pair_key.sv
// Top level: min priority queue of key pairs built as a sorted chain of cells.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in      | input     | in_valid/in_ready  | action, key_major, key_minor
//  out     | output    | out_valid/out_ready| min_major, min_minor, status,
//          |           |                    | entry_total, is_empty
//
// On each accepted transaction all cells compare the new pair in
// parallel and shift together, and the result appears in the output
// register on the next cycle. Cell 0 always holds the minimum.
// in_ready is high while the output register is empty or being drained, so
// one transaction per cycle is sustained when out_ready stays high.
// Reset clears the cell valid bits and the count; no clearing pass is needed.
// An output stall holds the result and blocks input until it is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module min_priority_queue_pair_key (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic signed [mpq_pkg::KEY_W-1:0]  key_major,
    input  logic signed [mpq_pkg::KEY_W-1:0]  key_minor,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mpq_pkg::KEY_W-1:0]  min_major,
    output logic signed [mpq_pkg::KEY_W-1:0]  min_minor,
    output logic [1:0]                        status,
    output logic [mpq_pkg::TOTAL_W-1:0]       entry_total,
    output logic                              is_empty
);
    import mpq_pkg::*;

    logic                in_fire;
    logic                is_full;
    logic                has_any;
    cell_ctrl_t          ctrl;
    cell_t               cells [CAPACITY];
    logic                less  [CAPACITY];

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    pair_t               res_reg, res_next;
    logic [1:0]          status_reg, status_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign has_any  = (count_reg != '0);

    // Broadcast operation to the chain
    always_comb
    begin
        ctrl.ins        = in_fire && (action == ACT_INSERT) && !is_full;
        ctrl.ext        = in_fire && (action == ACT_EXTRACT) && has_any;
        ctrl.pair.major = key_major;
        ctrl.pair.minor = key_minor;
    end

    // Sorted chain, cell 0 at the head
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            cell_t left_c, right_c;
            logic  left_l;
            if (gi == 0)
            begin : g_head
                assign left_c = '0;
                assign left_l = 1'b0;
            end
            else
            begin : g_mid
                assign left_c = cells[gi-1];
                assign left_l = less[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_c = '0;
            end
            else
            begin : g_inner
                assign right_c = cells[gi+1];
            end
            mpq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .left      (left_c),
                .left_less (left_l),
                .right     (right_c),
                .cur       (cells[gi]),
                .less      (less[gi])
            );
        end
    endgenerate

    // Result and count for the transaction being accepted
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        status_next    = status_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            res_next       = cells[0].pair;
            if (action == ACT_INSERT)
            begin
                if (is_full)
                    status_next = ST_FULL;
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (less[0])
                        res_next = ctrl.pair;
                end
            end
            else
            begin
                if (!has_any)
                begin
                    status_next = ST_EMPTY;
                    res_next    = '0;
                end
                else
                    count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign min_major   = res_reg.major;
    assign min_minor   = res_reg.minor;
    assign status      = status_reg;
    assign entry_total = TOTAL_W'(count_reg);
    assign is_empty    = (count_reg == '0);

    // Checks
    `MPQ_AST_HOLDS(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `MPQ_AST_HOLDS(a_head_valid, cells[0].valid == has_any, "head valid disagrees with count")
    `MPQ_AST_HOLDS(a_tail_full, !cells[CAPACITY-1].valid || is_full, "tail valid while not full")
    `MPQ_AST_HOLDS(a_head_order, !(cells[1].valid && pair_less(cells[1].pair, cells[0].pair)), "head not minimum")
    `MPQ_AST_NEXT(a_ins_count, ctrl.ins, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count")

endmodule
